>>> rtl/scpbp_pkg.sv
// Shared types, codes and default sizes for the start codon position profile block.
package scpbp_pkg;

  // Default sizes of the slot store and of each counter.
  localparam int unsigned WINDOW_SLOTS_DEF = 256;
  localparam int unsigned COUNT_BITS_DEF   = 32;

  // Fixed field widths of the ports.
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned NUM_BASES = 4;

  // The start codon plus three downstream bases follow the upstream flank.
  localparam int unsigned FLANK_SLOTS = 6;

  // Base codes as they arrive on the input.
  localparam logic [CODE_W-1:0] BASE_A = 3'd0;
  localparam logic [CODE_W-1:0] BASE_T = 3'd1;
  localparam logic [CODE_W-1:0] BASE_C = 3'd2;
  localparam logic [CODE_W-1:0] BASE_G = 3'd3;

  typedef enum logic {
    OP_BASE = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_READ    = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_READ,
    ST_VERDICT
  } state_e;

  // One stored window slot: present flag over the base code.
  typedef struct packed {
    logic              present;
    logic [CODE_W-1:0] code;
  } win_entry_t;

  // Expected base at each of the three centre slots.
  function automatic logic [CODE_W-1:0] centre_code(input logic [1:0] k);
    logic [CODE_W-1:0] c;
    case (k)
      2'd0:    c = BASE_A;
      2'd1:    c = BASE_T;
      default: c = BASE_G;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/scpbp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module scpbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/start_codon_position_base_profile_top.sv
// Top level of the start codon position profile: slot store, counter store and sequencer.
//
// Usage: the input channel carries either a window base (opcode 0) or a counter read
// (opcode 1). A window of upstream_len+6 bases is streamed one slot per request with the
// final one marked last. Base requests that are not last give no result. A last base
// starts a check of the three centre slots (three memory reads); on a match the
// sequencer walks the window once through the counter memory, one slot per cycle with
// read-modify-write, over min(upstream_len+6, WINDOW_SLOTS) slots. The verdict then goes
// to the output register. A read request reads its counter row and loads its five counts
// into the output register once that register is free.
// The output channel is a register: base requests are taken while a result waits. A read
// or a last base is taken even then; its result waits in the sequencer until the register
// frees, and in_stall_o stays high meanwhile. While the receiver stalls, the result and its
// fields stay put.
// After reset the counter memory is cleared one row per cycle, during which in_stall_o
// stays high; configuration writes are taken at any time. The user is bound to keep
// upstream_len written only while the block is idle; the block itself does not enforce this.
module start_codon_position_base_profile_top #(
  parameter int unsigned WINDOW_SLOTS = scpbp_pkg::WINDOW_SLOTS_DEF,
  parameter int unsigned COUNT_BITS   = scpbp_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic [scpbp_pkg::CFG_W-1:0]   cfg_wdata_i,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [scpbp_pkg::SLOT_W-1:0]  slot_i,
  input  logic [scpbp_pkg::CODE_W-1:0]  base_code_i,
  input  logic                          present_i,
  input  logic                          last_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic                          matched_o,
  output logic [scpbp_pkg::OUT_W-1:0]   total_count_o,
  output logic [scpbp_pkg::OUT_W-1:0]   count_a_o,
  output logic [scpbp_pkg::OUT_W-1:0]   count_t_o,
  output logic [scpbp_pkg::OUT_W-1:0]   count_c_o,
  output logic [scpbp_pkg::OUT_W-1:0]   count_g_o
);

  import scpbp_pkg::*;

  localparam int unsigned AW        = $clog2(WINDOW_SLOTS);
  localparam int unsigned CB        = COUNT_BITS;
  localparam int unsigned TOTAL_IDX = NUM_BASES;
  localparam int unsigned ROW_W     = (NUM_BASES + 1) * CB;
  localparam int unsigned WIN_W     = $bits(win_entry_t);
  localparam int unsigned POS_W     = (AW + 1 > CFG_W + 1) ? AW + 1 : CFG_W + 1;
  localparam logic [POS_W-1:0] SLOTS_POS = POS_W'(WINDOW_SLOTS);

  // Saturating counter increment.
  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    logic [CB-1:0] r;
    r = (&v) ? v : v + CB'(1);
    return r;
  endfunction

  // Counter shown on a 32-bit field, clipped at all ones.
  function automatic logic [OUT_W-1:0] show32(input logic [CB-1:0] v);
    logic [63:0]      w;
    logic [OUT_W-1:0] r;
    w = 64'(v);
    r = (|w[63:OUT_W]) ? '1 : w[OUT_W-1:0];
    return r;
  endfunction

  // Sequencer state.
  state_e           st_q, st_d;
  logic [CFG_W-1:0] upstream_len_q;
  logic [POS_W-1:0] idx_q, idx_d;
  logic [1:0]       k_q, k_d;
  logic             ok_q, ok_d;
  logic             matched_q, matched_d;

  // Tags of the read that is in flight through the memories.
  logic             p_chk_q, p_chk_d;
  logic             p_walk_q, p_walk_d;
  logic             p_inr_q, p_inr_d;
  logic [AW-1:0]    p_addr_q, p_addr_d;
  logic [1:0]       p_k_q, p_k_d;
  logic             rd_inr_q, rd_inr_d;

  // Output register.
  logic             out_valid_q;
  kind_e            out_kind_q, out_kind_d;
  logic             out_matched_q;
  logic [OUT_W-1:0] out_total_q, out_a_q, out_t_q, out_c_q, out_g_q;
  logic             out_load;

  // Memory ports.
  logic             win_we, win_re;
  logic [AW-1:0]    win_waddr, win_raddr;
  logic [WIN_W-1:0] win_wdata, win_rdata;
  logic             cnt_we, cnt_re;
  logic [AW-1:0]    cnt_waddr, cnt_raddr;
  logic [ROW_W-1:0] cnt_wdata, cnt_rdata, row_new;

  // Helpers.
  logic             in_acc, out_free, slot_inr, ctr_inr, cur_ok, chk_ok, walk_more;
  logic [POS_W-1:0] len_raw, len_pos, ctr_pos;
  win_entry_t       ent;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign slot_inr = POS_W'(slot_i) < SLOTS_POS;

  // Window length, limited to the store.
  assign len_raw   = POS_W'(upstream_len_q) + POS_W'(FLANK_SLOTS);
  assign len_pos   = (len_raw > SLOTS_POS) ? SLOTS_POS : len_raw;
  assign walk_more = idx_q < len_pos;

  // Centre slot address for the current check step.
  assign ctr_pos = POS_W'(upstream_len_q) + POS_W'(k_q);
  assign ctr_inr = ctr_pos < SLOTS_POS;

  // Centre check on the slot that came back from the store.
  assign ent    = win_entry_t'(win_rdata);
  assign cur_ok = p_inr_q && ent.present && (ent.code == centre_code(p_k_q));
  assign chk_ok = ok_q && (!p_chk_q || cur_ok);

  // Counter row after one present slot of a matched window.
  always_comb begin
    row_new = cnt_rdata;
    if (ent.present) begin
      row_new[TOTAL_IDX*CB +: CB] = sat_inc(cnt_rdata[TOTAL_IDX*CB +: CB]);
      if (ent.code <= BASE_G) begin
        row_new[ent.code[1:0]*CB +: CB] = sat_inc(cnt_rdata[ent.code[1:0]*CB +: CB]);
      end
    end
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR: begin
        if (idx_q == SLOTS_POS - POS_W'(1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == OP_READ) begin
            st_d = ST_READ;
          end else if (last_i) begin
            st_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (k_q == 2'd3) begin
          st_d = chk_ok ? ST_WALK : ST_VERDICT;
        end
      end
      ST_WALK: begin
        if (!walk_more) begin
          st_d = ST_VERDICT;
        end
      end
      ST_READ, ST_VERDICT: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: memory controls, handshake and datapath updates.
  always_comb begin
    in_stall_o = 1'b1;
    win_we     = 1'b0;
    win_waddr  = AW'(slot_i);
    win_wdata  = {present_i, base_code_i};
    win_re     = 1'b0;
    win_raddr  = idx_q[AW-1:0];
    cnt_we     = 1'b0;
    cnt_waddr  = p_addr_q;
    cnt_wdata  = row_new;
    cnt_re     = 1'b0;
    cnt_raddr  = idx_q[AW-1:0];
    idx_d      = idx_q;
    k_d        = k_q;
    ok_d       = ok_q;
    matched_d  = matched_q;
    p_chk_d    = 1'b0;
    p_walk_d   = 1'b0;
    p_inr_d    = p_inr_q;
    p_addr_d   = p_addr_q;
    p_k_d      = p_k_q;
    rd_inr_d   = rd_inr_q;
    out_load   = 1'b0;
    out_kind_d = KIND_VERDICT;
    unique case (st_q)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = idx_q[AW-1:0];
        cnt_wdata = '0;
        idx_d     = (idx_q == SLOTS_POS - POS_W'(1)) ? '0 : idx_q + POS_W'(1);
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          if (opcode_i == OP_READ) begin
            cnt_re    = slot_inr;
            cnt_raddr = AW'(slot_i);
            rd_inr_d  = slot_inr;
          end else begin
            win_we = slot_inr;
            if (last_i) begin
              k_d  = 2'd0;
              ok_d = 1'b1;
            end
          end
        end
      end
      ST_CHECK: begin
        ok_d = chk_ok;
        if (k_q != 2'd3) begin
          win_re    = ctr_inr;
          win_raddr = ctr_pos[AW-1:0];
          p_chk_d   = 1'b1;
          p_inr_d   = ctr_inr;
          p_k_d     = k_q;
          k_d       = k_q + 2'd1;
        end else begin
          matched_d = chk_ok;
          idx_d     = '0;
        end
      end
      ST_WALK: begin
        // Write back the slot read last cycle while the next one is read.
        cnt_we = p_walk_q && ent.present;
        if (walk_more) begin
          win_re   = 1'b1;
          cnt_re   = 1'b1;
          p_walk_d = 1'b1;
          p_addr_d = idx_q[AW-1:0];
          idx_d    = idx_q + POS_W'(1);
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_READ;
        end
      end
      ST_VERDICT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_VERDICT;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= ST_CLEAR;
      upstream_len_q <= '0;
      idx_q          <= '0;
      k_q            <= '0;
      ok_q           <= 1'b0;
      matched_q      <= 1'b0;
      p_chk_q        <= 1'b0;
      p_walk_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      st_q      <= st_d;
      idx_q     <= idx_d;
      k_q       <= k_d;
      ok_q      <= ok_d;
      matched_q <= matched_d;
      p_chk_q   <= p_chk_d;
      p_walk_q  <= p_walk_d;
      if (cfg_we_i) begin
        upstream_len_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    p_inr_q  <= p_inr_d;
    p_addr_q <= p_addr_d;
    p_k_q    <= p_k_d;
    rd_inr_q <= rd_inr_d;
    if (out_load) begin
      out_kind_q    <= out_kind_d;
      out_matched_q <= (out_kind_d == KIND_VERDICT) && matched_q;
      if (out_kind_d == KIND_READ && rd_inr_q) begin
        out_total_q <= show32(cnt_rdata[TOTAL_IDX*CB +: CB]);
        out_a_q     <= show32(cnt_rdata[0*CB +: CB]);
        out_t_q     <= show32(cnt_rdata[1*CB +: CB]);
        out_c_q     <= show32(cnt_rdata[2*CB +: CB]);
        out_g_q     <= show32(cnt_rdata[3*CB +: CB]);
      end else begin
        out_total_q <= '0;
        out_a_q     <= '0;
        out_t_q     <= '0;
        out_c_q     <= '0;
        out_g_q     <= '0;
      end
    end
  end

  // Window slot store.
  scpbp_ram #(
    .WIDTH(WIN_W),
    .DEPTH(WINDOW_SLOTS)
  ) u_win_ram (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .waddr_i(win_waddr),
    .wdata_i(win_wdata),
    .re_i   (win_re),
    .raddr_i(win_raddr),
    .rdata_o(win_rdata)
  );

  // Counter store: one row per slot with four base counters and the total.
  scpbp_ram #(
    .WIDTH(ROW_W),
    .DEPTH(WINDOW_SLOTS)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .re_i   (cnt_re),
    .raddr_i(cnt_raddr),
    .rdata_o(cnt_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign matched_o     = out_matched_q;
  assign total_count_o = out_total_q;
  assign count_a_o     = out_a_q;
  assign count_t_o     = out_t_q;
  assign count_c_o     = out_c_q;
  assign count_g_o     = out_g_q;

  // The walk never reads a counter row in the cycle it is written back.
  a_no_rmw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_we && cnt_re) |-> (cnt_waddr != cnt_raddr))
    else $error("counter row read and written in the same cycle");

  // A new result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_valid_q) |-> !out_stall_i)
    else $error("waiting result overwritten");

  // A matched verdict only follows a walk over the window.
  a_match_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_kind_d == KIND_VERDICT && matched_q) |->
      ($past(st_q) == ST_WALK || $past(st_q) == ST_VERDICT))
    else $error("matched verdict without a counter walk");

  // Read results never carry a match flag.
  a_read_unmatched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_READ) |-> !matched_o)
    else $error("read result flagged as matched");

endmodule

>>> tb/tb_start_codon_position_base_profile_top.sv
// Self-checking testbench for the start codon position profile block.
`timescale 1ns / 1ps

module tb_start_codon_position_base_profile_top;
  import scpbp_pkg::*;

  localparam int unsigned SLOTS        = WINDOW_SLOTS_DEF;
  localparam int unsigned LAST_SLOT    = SLOTS - 1;
  localparam int unsigned DIR_ROWS     = 25;
  localparam int unsigned RANDOM_ITEMS = 700;
  // Longer than one full commit walk of the counter store plus the check.
  localparam int unsigned DRAIN_PAUSE  = 300;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  // Base codes beyond g all count as "other".
  localparam logic [CODE_W-1:0] BASE_OTHER     = 3'd4;
  localparam logic [CODE_W-1:0] BASE_OTHER_MAX = 3'd7;
  localparam logic [CODE_W-1:0] START_CODON [3] = '{BASE_A, BASE_T, BASE_G};

  typedef struct packed {
    opcode_e           op;
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] code;
    logic              present;
    logic              last;
  } base_req_t;

  typedef struct packed {
    kind_e            kind;
    logic             matched;
    logic [OUT_W-1:0] total;
    logic [OUT_W-1:0] cnt_a;
    logic [OUT_W-1:0] cnt_t;
    logic [OUT_W-1:0] cnt_c;
    logic [OUT_W-1:0] cnt_g;
  } profile_t;

  // A directed row; typed rows carry an all-zero count result or a plain verdict.
  typedef struct packed {
    base_req_t req;
    logic      typed;
    logic      want_matched;
  } dir_row_t;

  // Directed requests, run with upstream_len at its reset value of zero.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{OP_READ, 8'd0,   BASE_A,         1'b0, 1'b0}, 1'b1, 1'b0},
    '{'{OP_READ, 8'd255, BASE_OTHER_MAX, 1'b1, 1'b1}, 1'b1, 1'b0},
    '{'{OP_BASE, 8'd0,   BASE_A,         1'b1, 1'b0}, 1'b0, 1'b0},
    '{'{OP_BASE, 8'd1,   BASE_T,         1'b1, 1'b0}, 1'b0, 1'b0},
    '{'{OP_BASE, 8'd2,   BASE_G,         1'b1, 1'b0}, 1'b0, 1'b0},
    '{'{OP_BASE, 8'd3,   BASE_OTHER_MAX, 1'b1, 1'b0}, 1'b0, 1'b0},
    '{'{OP_BASE, 8'd4,   BASE_C,         1'b0, 1'b0}, 1'b0, 1'b0},
    '{'{OP_BASE, 8'd5,   BASE_G,         1'b1, 1'b1}, 1'b1, 1'b1},
    '{'{OP_READ, 8'd0,   BASE_A,         1'b0, 1'b0}, 1'b0, 1'b0},
    '{'{OP_READ, 8'd3,   BASE_A,         1'b0, 1'b0}, 1'b0, 1'b0},
    '{'{OP_READ, 8'd4,   BASE_A,         1'b0, 1'b0}, 1'b1, 1'b0},
    '{'{OP_BASE, 8'd1,   BASE_C,         1'b1, 1'b1}, 1'b1, 1'b0},
    '{'{OP_BASE, 8'd1,   BASE_T,         1'b0, 1'b1}, 1'b1, 1'b0},
    '{'{OP_BASE, 8'd1,   BASE_T,         1'b1, 1'b0}, 1'b0, 1'b0},
    '{'{OP_BASE, 8'd9,   BASE_G,         1'b1, 1'b0}, 1'b0, 1'b0},
    '{'{OP_BASE, 8'd4,   BASE_OTHER,     1'b1, 1'b1}, 1'b1, 1'b1},
    '{'{OP_READ, 8'd9,   BASE_A,         1'b0, 1'b0}, 1'b1, 1'b0},
    '{'{OP_READ, 8'd4,   BASE_A,         1'b0, 1'b0}, 1'b0, 1'b0},
    '{'{OP_READ, 8'd5,   BASE_A,         1'b0, 1'b0}, 1'b0, 1'b0},
    '{'{OP_BASE, 8'd2,   BASE_OTHER_MAX, 1'b1, 1'b1}, 1'b1, 1'b0},
    '{'{OP_BASE, 8'd2,   BASE_G,         1'b1, 1'b0}, 1'b0, 1'b0},
    '{'{OP_BASE, 8'd255, BASE_OTHER,     1'b0, 1'b0}, 1'b0, 1'b0},
    '{'{OP_BASE, 8'd5,   BASE_T,         1'b1, 1'b1}, 1'b1, 1'b1},
    '{'{OP_READ, 8'd1,   BASE_A,         1'b0, 1'b0}, 1'b0, 1'b0},
    '{'{OP_READ, 8'd2,   BASE_A,         1'b0, 1'b0}, 1'b0, 1'b0}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                opcode_i    = 1'b0;
  logic [SLOT_W-1:0]   slot_i      = '0;
  logic [CODE_W-1:0]   base_code_i = '0;
  logic                present_i   = 1'b0;
  logic                last_i      = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                kind_o;
  logic                matched_o;
  logic [OUT_W-1:0]    total_count_o;
  logic [OUT_W-1:0]    count_a_o;
  logic [OUT_W-1:0]    count_t_o;
  logic [OUT_W-1:0]    count_c_o;
  logic [OUT_W-1:0]    count_g_o;

  // Profile predictor state: window store, written flags and counters.
  win_entry_t       win_store     [SLOTS];
  bit               slot_written  [SLOTS];
  logic [OUT_W-1:0] slot_total    [SLOTS];
  logic [OUT_W-1:0] slot_base_cnt [SLOTS][NUM_BASES];
  int unsigned      upstream_cfg;

  profile_t    expected_q [$];
  int unsigned req_count;
  int unsigned burst_left;
  int unsigned fail_count = 0;
  int unsigned cycle_cnt  = 0;

  start_codon_position_base_profile_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .slot_i        (slot_i),
    .base_code_i   (base_code_i),
    .present_i     (present_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .matched_o     (matched_o),
    .total_count_o (total_count_o),
    .count_a_o     (count_a_o),
    .count_t_o     (count_t_o),
    .count_c_o     (count_c_o),
    .count_g_o     (count_g_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result stall pattern: quiet stretches, light, heavy and solid stalling.
  always @(posedge clk_i) begin
    int unsigned stall_mode;
    int unsigned stall_run;
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = (stall_mode == 3) ? $urandom_range(2, 30) : $urandom_range(8, 60);
    end else begin
      stall_run = stall_run - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= 1'b1;
    endcase
  end

  function automatic void check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare every accepted result with the oldest expected profile result.
  always @(posedge clk_i) begin
    profile_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d matched %0d", kind_o, matched_o);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", OUT_W'(want.kind), OUT_W'(kind_o));
        check_field("matched", OUT_W'(want.matched), OUT_W'(matched_o));
        check_field("total_count", want.total, total_count_o);
        check_field("count_a", want.cnt_a, count_a_o);
        check_field("count_t", want.cnt_t, count_t_o);
        check_field("count_c", want.cnt_c, count_c_o);
        check_field("count_g", want.cnt_g, count_g_o);
      end
    end
  end

  function automatic logic [OUT_W-1:0] sat_incr(logic [OUT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Predict the result of one request and advance the profile state.
  function automatic bit profile_predict(input base_req_t r, output profile_t res);
    bit          matched;
    int unsigned s;
    int unsigned span;
    res = '0;
    res.kind = KIND_VERDICT;
    if (r.op == OP_READ) begin
      res.kind  = KIND_READ;
      res.total = slot_total[r.slot];
      res.cnt_a = slot_base_cnt[r.slot][BASE_A];
      res.cnt_t = slot_base_cnt[r.slot][BASE_T];
      res.cnt_c = slot_base_cnt[r.slot][BASE_C];
      res.cnt_g = slot_base_cnt[r.slot][BASE_G];
      return 1'b1;
    end
    win_store[r.slot]    = '{present: r.present, code: r.code};
    slot_written[r.slot] = 1'b1;
    if (!r.last) return 1'b0;
    // The three centre slots must hold a present start codon inside the store.
    matched = 1'b1;
    for (int unsigned k = 0; k < 3; k++) begin
      s = upstream_cfg + k;
      if (s >= SLOTS) matched = 1'b0;
      else if (!win_store[s].present || win_store[s].code != START_CODON[k]) matched = 1'b0;
    end
    if (matched) begin
      span = (upstream_cfg + FLANK_SLOTS > SLOTS) ? SLOTS : upstream_cfg + FLANK_SLOTS;
      for (s = 0; s < span; s++) begin
        if (win_store[s].present) begin
          slot_total[s] = sat_incr(slot_total[s]);
          if (win_store[s].code <= BASE_G)
            slot_base_cnt[s][win_store[s].code] = sat_incr(slot_base_cnt[s][win_store[s].code]);
        end
      end
    end
    res.matched = matched;
    return 1'b1;
  endfunction

  // A verdict may only be asked for once every slot the window touches is written.
  function automatic bit window_ready(int unsigned up);
    for (int unsigned s = 0; s < up + FLANK_SLOTS && s < SLOTS; s++)
      if (!slot_written[s]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [CODE_W-1:0] random_code();
    if ($urandom_range(0, 9) < 8) return CODE_W'($urandom_range(BASE_A, BASE_G));
    return CODE_W'($urandom_range(BASE_OTHER, BASE_OTHER_MAX));
  endfunction

  // Drive one request in bursts with random gaps and record its expected result.
  task automatic send_req(input base_req_t r, input bit typed, input profile_t want);
    int unsigned gap;
    profile_t    pred;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= r.op;
    slot_i      <= r.slot;
    base_code_i <= r.code;
    present_i   <= r.present;
    last_i      <= r.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    req_count++;
    if (profile_predict(r, pred)) expected_q.push_back(typed ? want : pred);
  endtask

  task automatic send_read(input int unsigned span);
    base_req_t r;
    r.op      = OP_READ;
    r.slot    = ($urandom_range(0, 3) != 0) ? SLOT_W'($urandom_range(0, span - 1))
                                            : SLOT_W'($urandom_range(0, LAST_SLOT));
    r.code    = CODE_W'($urandom_range(BASE_A, BASE_OTHER_MAX));
    r.present = 1'($urandom_range(0, 1));
    r.last    = 1'($urandom_range(0, 1));
    send_req(r, 1'b0, '0);
  endtask

  // Stop requests, wait for all results, then let the block settle.
  task automatic drain_and_pause();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  task automatic write_upstream(input int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    upstream_cfg = value;
  endtask

  // Stream a window from slot first up to its last slot, or cut it short when broken.
  task automatic stream_window(input int unsigned up, input int unsigned first,
                               input int unsigned atg_pct, input bit broken);
    int unsigned span;
    int unsigned stop;
    int unsigned absent_to;
    int unsigned s;
    bit          want_atg;
    base_req_t   r;
    span      = (up + FLANK_SLOTS > SLOTS) ? SLOTS : up + FLANK_SLOTS;
    stop      = broken ? $urandom_range(first + 1, span - 1) : span;
    absent_to = ($urandom_range(0, 3) == 0) ? $urandom_range(0, up) : 0;
    want_atg  = ($urandom_range(0, 99) < atg_pct);
    for (s = first; s < stop; s++) begin
      r.op      = OP_BASE;
      r.slot    = SLOT_W'(s);
      r.code    = random_code();
      r.present = (s >= absent_to);
      if (want_atg && s >= up && s < up + 3) begin
        r.code    = START_CODON[s - up];
        r.present = 1'b1;
      end
      r.last = (s == span - 1);
      send_req(r, 1'b0, '0);
      if ($urandom_range(0, 7) == 0) send_read(span);
    end
  endtask

  // One phase at a fixed upstream length: mostly whole windows, some broken ones and noise.
  task automatic mix_phase(input int unsigned up);
    int unsigned pick;
    int unsigned span;
    base_req_t   r;
    span = (up + FLANK_SLOTS > SLOTS) ? SLOTS : up + FLANK_SLOTS;
    repeat ($urandom_range(4, 10)) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        stream_window(up, 0, 80, 1'b0);
      end else if (pick < 85) begin
        stream_window(up, 0, 80, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) begin
            send_read(span);
          end else begin
            r.op      = OP_BASE;
            r.slot    = $urandom_range(0, 1) ? SLOT_W'($urandom_range(0, span - 1))
                                             : SLOT_W'($urandom_range(0, LAST_SLOT));
            r.code    = CODE_W'($urandom_range(BASE_A, BASE_OTHER_MAX));
            r.present = 1'($urandom_range(0, 1));
            r.last    = ($urandom_range(0, 2) == 0) && window_ready(up);
            send_req(r, 1'b0, '0);
          end
        end
      end
    end
  endtask

  initial begin
    profile_t    want;
    int unsigned up;
    for (int unsigned s = 0; s < SLOTS; s++) begin
      win_store[s]    = '0;
      slot_written[s] = 1'b0;
      slot_total[s]   = '0;
      for (int unsigned b = 0; b < NUM_BASES; b++) slot_base_cnt[s][b] = '0;
    end
    upstream_cfg = 0;
    req_count    = 0;
    burst_left   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table at the reset upstream length.
    for (int unsigned i = 0; i < DIR_ROWS; i++) begin
      want         = '0;
      want.kind    = (DIR_TABLE[i].req.op == OP_READ) ? KIND_READ : KIND_VERDICT;
      want.matched = DIR_TABLE[i].want_matched;
      send_req(DIR_TABLE[i].req, DIR_TABLE[i].typed, want);
    end

    // Largest window, then windows that run past the end of the store.
    drain_and_pause();
    write_upstream(250);
    stream_window(250, 0, 100, 1'b0);
    drain_and_pause();
    write_upstream(251);
    stream_window(251, 248, 100, 1'b0);
    drain_and_pause();
    write_upstream(255);
    stream_window(255, 250, 100, 1'b0);

    // Random phases, starting with an empty upstream flank.
    up = 0;
    while (req_count < DIR_ROWS + RANDOM_ITEMS) begin
      drain_and_pause();
      write_upstream(up);
      mix_phase(up);
      up = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 60);
    end

    drain_and_pause();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/scpbp_pkg.sv
rtl/scpbp_ram.sv
rtl/start_codon_position_base_profile_top.sv
tb/tb_start_codon_position_base_profile_top.sv
